// File: hdl/rar_pkg.sv
// Shared types, widths and codes of the record averaging accumulator.
package rar_pkg;

	localparam int unsigned RECORD_LEN = 16384;
	localparam int unsigned ADDR_W     = (RECORD_LEN > 1) ? $clog2(RECORD_LEN) : 1;
	localparam int unsigned TAG_W      = 8;
	localparam int unsigned SUM_W      = 64;
	localparam int unsigned WORD_W     = SUM_W + TAG_W;
	localparam int unsigned SHOT_W     = 40;
	localparam int unsigned TOT_W      = 41;
	localparam int unsigned TGT_W      = 32;
	localparam int unsigned INC_W      = 32;
	localparam int unsigned VAL_W      = 48;
	localparam int unsigned IDX_W      = 14;
	localparam int unsigned SHIFT_W    = 15;
	localparam int unsigned CMD_W      = 3;
	localparam int unsigned ST_W       = 2;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_W      = 32;
	localparam int unsigned POS_W      = 22;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [TAG_W-1:0]  tag_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [WORD_W-1:0] word_t;

	localparam addr_t LAST_ADDR = addr_t'(RECORD_LEN - 1);
	localparam pos_t  LEN_POS   = pos_t'(RECORD_LEN);
	localparam tag_t  TAG_NONE  = '0;
	localparam tag_t  TAG_FIRST = tag_t'(1);
	localparam tag_t  TAG_LAST  = '1;
	localparam logic [SHOT_W-1:0] SHOT_MAX = '1;

	localparam logic [CMD_W-1:0] CMD_RAW   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SHIFT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_AVG   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SUB   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COPY  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
	localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SHIFT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'b1;

	typedef struct packed {
		logic             start;
		logic             neg;
		sum_t             mag;
		logic [TGT_W-1:0] num;
		logic [TOT_W-1:0] den;
	} scale_req_t;

	typedef struct packed {
		logic done;
		sum_t result;
	} scale_rsp_t;

endpackage

// File: hdl/rar_if.sv
// Valid/ready channels for sample input and result output.
interface rar_in_if;
	logic                          valid;
	logic                          ready;
	logic [rar_pkg::CMD_W-1:0]     cmd;
	logic [rar_pkg::IDX_W-1:0]     sample_index;
	logic signed [rar_pkg::VAL_W-1:0] sample_value;
	logic [rar_pkg::INC_W-1:0]     incoming_shots;
	logic                          last_sample;
	modport source (output valid, cmd, sample_index, sample_value, incoming_shots,
		last_sample, input ready);
	modport sink (input valid, cmd, sample_index, sample_value, incoming_shots,
		last_sample, output ready);
endinterface

interface rar_out_if;
	logic                          valid;
	logic                          ready;
	logic [rar_pkg::IDX_W-1:0]     out_index;
	logic signed [rar_pkg::SUM_W-1:0] out_sum;
	logic [rar_pkg::SHOT_W-1:0]    out_shots;
	logic                          record_done;
	logic [rar_pkg::ST_W-1:0]      status;
	modport source (output valid, out_index, out_sum, out_shots, record_done, status,
		input ready);
	modport sink (input valid, out_index, out_sum, out_shots, record_done, status,
		output ready);
endinterface

// File: hdl/rar_ram.sv
// Generic simple dual-port RAM with registered read.
module rar_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/rar_scale.sv
// Scaler: round(sign * mag * num / den), ties away from zero, saturated to 64 bits.
module rar_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  rar_pkg::scale_req_t req,
	output rar_pkg::scale_rsp_t rsp
);

	localparam int unsigned DVD_W = rar_pkg::SUM_W + rar_pkg::TGT_W;
	localparam int unsigned CNT_W = $clog2(DVD_W);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

	typedef enum logic [2:0] {S_IDLE, S_MUL0, S_MUL1, S_ADD, S_DIV, S_FIN} state_t;

	state_t                        state_q;
	logic                          neg_q;
	rar_pkg::sum_t                 mag_q;
	logic [rar_pkg::TGT_W-1:0]     num_q;
	logic [rar_pkg::TOT_W-1:0]     den_q;
	logic [63:0]                   p0_q;
	logic [63:0]                   p1_q;
	logic [DVD_W-1:0]              dvd_q;
	logic [rar_pkg::TOT_W-1:0]     rem_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          done_q;
	rar_pkg::sum_t                 result_q;

	logic [31:0]                   mul_a;
	logic [63:0]                   prod;
	logic [rar_pkg::TOT_W:0]       trial;
	logic [rar_pkg::TOT_W:0]       shifted;
	logic                          ge;
	rar_pkg::sum_t                 sat;

	always_comb begin
		mul_a   = (state_q == S_MUL0) ? mag_q[31:0] : mag_q[63:32];
		prod    = mul_a * num_q;
		shifted = {rem_q, dvd_q[DVD_W-1]};
		trial   = shifted - {1'b0, den_q};
		ge      = !trial[rar_pkg::TOT_W];
		if (!neg_q) begin
			sat = (dvd_q[DVD_W-1:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : dvd_q[63:0];
		end else if (dvd_q[DVD_W-1:64] != '0 || (dvd_q[63] && dvd_q[62:0] != '0)) begin
			sat = 64'h8000_0000_0000_0000;
		end else begin
			sat = ~dvd_q[63:0] + 64'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						neg_q   <= req.neg;
						mag_q   <= req.mag;
						num_q   <= req.num;
						den_q   <= req.den;
						state_q <= S_MUL0;
					end
				end
				S_MUL0: begin
					p0_q    <= prod;
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					p1_q    <= prod;
					state_q <= S_ADD;
				end
				S_ADD: begin
					dvd_q   <= {32'd0, p0_q} + {p1_q, 32'd0}
						+ DVD_W'(den_q >> 1);
					rem_q   <= '0;
					cnt_q   <= DIV_LAST;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= ge ? trial[rar_pkg::TOT_W-1:0] : shifted[rar_pkg::TOT_W-1:0];
					dvd_q <= {dvd_q[DVD_W-2:0], ge};
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_FIN: begin
					result_q <= sat;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

// File: hdl/record_averaging_accumulator.sv
// Record averaging accumulator: sum store, shot count and rolling-average control.
//
// channel  | dir | transaction
// samples  | in  | cmd, sample_index, sample_value, incoming_shots, last_sample
// results  | out | out_index, out_sum, out_shots, record_done, status
// cfg      | in  | cfg_we, cfg_index, cfg_wdata (no handshake)
//
// One item at a time through the store's read-modify-write; a scaled item also
// passes through the bit-serial divider (one quotient bit a cycle). A scaled
// average's last item adds a rescale sweep over the store that scales each
// untouched entry and passes over touched ones. Once the epoch tag has reached
// its last value, the next average start adds a retag sweep over every entry.
// After reset the store is cleared entry by entry with samples.ready low. A result
// waiting at the output holds only the next item's final state.
module record_averaging_accumulator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rar_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rar_pkg::CFG_W-1:0]         cfg_wdata,
	rar_in_if.sink                            samples,
	rar_out_if.source                         results
);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_ERD, ST_EDAT, ST_EDIV, ST_ENDI,
		ST_PRD, ST_PDAT, ST_PDIV, ST_FIN
	} state_t;

	state_t                          state_q;
	rar_pkg::addr_t                  cnt_q;
	logic                            retag_q;
	logic [rar_pkg::SHIFT_W-1:0]     shift_q;
	logic [rar_pkg::TGT_W-1:0]       target_q;
	logic [rar_pkg::SHOT_W-1:0]      shot_q;
	logic [rar_pkg::TOT_W-1:0]       total_q;
	logic                            active_q;
	rar_pkg::tag_t                   epoch_q;
	logic [rar_pkg::CMD_W-1:0]       cmd_q;
	rar_pkg::sum_t                   val_q;
	logic [rar_pkg::INC_W-1:0]       inc_q;
	logic                            last_q;
	rar_pkg::addr_t                  addr_q;
	logic                            inr_q;
	logic                            scaling_q;
	rar_pkg::sum_t                   res_sum_q;
	logic                            res_wrote_q;
	logic [rar_pkg::ST_W-1:0]        res_status_q;
	logic                            ovalid_q;
	rar_pkg::idx_t                   oindex_q;
	rar_pkg::sum_t                   osum_q;
	logic [rar_pkg::SHOT_W-1:0]      oshots_q;
	logic                            odone_q;
	logic [rar_pkg::ST_W-1:0]        ostatus_q;

	logic                            acc;
	rar_pkg::pos_t                   pos;
	logic                            inr;
	logic                            start;
	logic [rar_pkg::TOT_W-1:0]       total_eff;
	logic                            scaling_in;
	logic                            ram_we;
	rar_pkg::addr_t                  ram_waddr;
	rar_pkg::word_t                  ram_wdata;
	logic                            ram_re;
	rar_pkg::addr_t                  ram_raddr;
	rar_pkg::word_t                  ram_rdata;
	rar_pkg::sum_t                   old;
	rar_pkg::tag_t                   rtag;
	rar_pkg::sum_t                   tsum;
	rar_pkg::sum_t                   new_sum;
	logic                            avg_neg;
	logic                            edat_we;
	logic                            edat_wrote;
	logic                            untouched;
	rar_pkg::scale_req_t             sreq;
	rar_pkg::scale_rsp_t             srsp;
	logic [rar_pkg::TOT_W-1:0]       shot_inc;
	logic [rar_pkg::TOT_W-1:0]       shot_one;

	assign samples.ready = (state_q == ST_IDLE);
	assign acc = samples.valid && samples.ready;

	always_comb begin
		pos = {{(rar_pkg::POS_W - rar_pkg::IDX_W){1'b0}}, samples.sample_index};
		if (samples.cmd == rar_pkg::CMD_SHIFT || samples.cmd == rar_pkg::CMD_AVG) begin
			pos = pos + {{(rar_pkg::POS_W - rar_pkg::SHIFT_W){shift_q[rar_pkg::SHIFT_W-1]}},
				shift_q};
		end
		inr        = !pos[rar_pkg::POS_W-1] && (pos < rar_pkg::LEN_POS);
		start      = (samples.cmd == rar_pkg::CMD_AVG) && !active_q;
		total_eff  = start ? ({1'b0, shot_q} + rar_pkg::TOT_W'(samples.incoming_shots))
			: total_q;
		scaling_in = (samples.cmd == rar_pkg::CMD_AVG)
			&& (total_eff > rar_pkg::TOT_W'(target_q));
	end

	always_comb begin
		old        = ram_rdata[rar_pkg::SUM_W-1:0];
		rtag       = ram_rdata[rar_pkg::WORD_W-1:rar_pkg::SUM_W];
		tsum       = old + val_q;
		avg_neg    = (old[63] == val_q[63]) ? old[63] : tsum[63];
		case (cmd_q)
			rar_pkg::CMD_SUB:  new_sum = old - val_q;
			rar_pkg::CMD_COPY: new_sum = val_q;
			rar_pkg::CMD_READ: new_sum = old;
			default:           new_sum = tsum;
		endcase
		edat_wrote = inr_q && (cmd_q <= rar_pkg::CMD_READ);
		edat_we    = inr_q && (cmd_q <= rar_pkg::CMD_COPY) && !scaling_q;
		untouched  = (rtag != epoch_q);
		shot_inc   = {1'b0, shot_q} + rar_pkg::TOT_W'(inc_q);
		shot_one   = {1'b0, shot_q} + rar_pkg::TOT_W'(1);

		sreq.num = target_q;
		sreq.den = total_q;
		if (state_q == ST_PDAT) begin
			sreq.start = !retag_q && untouched;
			sreq.neg   = old[63];
			sreq.mag   = old[63] ? (~old + 64'd1) : old;
		end else begin
			sreq.start = (state_q == ST_EDAT) && inr_q && scaling_q;
			sreq.neg   = avg_neg;
			sreq.mag   = avg_neg ? (~tsum + 64'd1) : tsum;
		end

		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {rar_pkg::TAG_NONE, new_sum};
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = '0;
			end
			ST_ERD: ram_re = 1'b1;
			ST_EDAT: ram_we = edat_we;
			ST_EDIV: begin
				ram_we    = srsp.done;
				ram_wdata = {epoch_q, srsp.result};
			end
			ST_PRD: begin
				ram_re    = 1'b1;
				ram_raddr = cnt_q;
			end
			ST_PDAT: begin
				ram_we    = retag_q;
				ram_waddr = cnt_q;
				ram_wdata = {rar_pkg::TAG_NONE, old};
			end
			ST_PDIV: begin
				ram_we    = srsp.done;
				ram_waddr = cnt_q;
				ram_wdata = {rar_pkg::TAG_NONE, srsp.result};
			end
			default: ram_we = 1'b0;
		endcase
	end

	rar_ram #(
		.WIDTH (rar_pkg::WORD_W),
		.DEPTH (rar_pkg::RECORD_LEN)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rar_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.rsp    (srsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			cnt_q    <= '0;
			retag_q  <= 1'b0;
			shift_q  <= '0;
			target_q <= rar_pkg::TGT_W'(1);
			shot_q   <= '0;
			total_q  <= '0;
			active_q <= 1'b0;
			epoch_q  <= rar_pkg::TAG_NONE;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rar_pkg::REG_SHIFT:  shift_q  <= cfg_wdata[rar_pkg::SHIFT_W-1:0];
					rar_pkg::REG_TARGET: target_q <= cfg_wdata[rar_pkg::TGT_W-1:0];
					default: ;
				endcase
			end
			if (results.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					if (cnt_q == rar_pkg::LAST_ADDR) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						cmd_q     <= samples.cmd;
						val_q     <= {{(rar_pkg::SUM_W - rar_pkg::VAL_W)
							{samples.sample_value[rar_pkg::VAL_W-1]}}, samples.sample_value};
						inc_q     <= samples.incoming_shots;
						last_q    <= samples.last_sample;
						addr_q    <= pos[rar_pkg::ADDR_W-1:0];
						inr_q     <= inr;
						scaling_q <= scaling_in;
						state_q   <= ST_ERD;
						if (samples.cmd != rar_pkg::CMD_AVG) begin
							active_q <= 1'b0;
						end
						if (start) begin
							active_q <= 1'b1;
							total_q  <= total_eff;
							if (epoch_q == rar_pkg::TAG_LAST) begin
								epoch_q <= rar_pkg::TAG_FIRST;
								retag_q <= 1'b1;
								cnt_q   <= '0;
								state_q <= ST_PRD;
							end else begin
								epoch_q <= epoch_q + 1'b1;
							end
						end
					end
				end
				ST_ERD: state_q <= ST_EDAT;
				ST_EDAT: begin
					res_wrote_q <= edat_wrote;
					res_sum_q   <= new_sum;
					state_q     <= sreq.start ? ST_EDIV : ST_ENDI;
				end
				ST_EDIV: begin
					if (srsp.done) begin
						res_sum_q <= srsp.result;
						state_q   <= ST_ENDI;
					end
				end
				ST_ENDI: begin
					res_status_q <= rar_pkg::ST_OK;
					state_q      <= ST_FIN;
					if (last_q) begin
						case (cmd_q)
							rar_pkg::CMD_RAW, rar_pkg::CMD_COPY: begin
								if (shot_one[rar_pkg::SHOT_W]) begin
									shot_q       <= rar_pkg::SHOT_MAX;
									res_status_q <= rar_pkg::ST_SAT;
								end else begin
									shot_q <= shot_one[rar_pkg::SHOT_W-1:0];
								end
							end
							rar_pkg::CMD_SHIFT: begin
								if (shot_inc[rar_pkg::SHOT_W]) begin
									shot_q       <= rar_pkg::SHOT_MAX;
									res_status_q <= rar_pkg::ST_SAT;
								end else begin
									shot_q <= shot_inc[rar_pkg::SHOT_W-1:0];
								end
							end
							rar_pkg::CMD_SUB: begin
								if (rar_pkg::SHOT_W'(inc_q) > shot_q) begin
									shot_q       <= '0;
									res_status_q <= rar_pkg::ST_UNDER;
								end else begin
									shot_q <= shot_q - rar_pkg::SHOT_W'(inc_q);
								end
							end
							rar_pkg::CMD_AVG: begin
								active_q <= 1'b0;
								if (scaling_q) begin
									shot_q  <= rar_pkg::SHOT_W'(target_q);
									retag_q <= 1'b0;
									cnt_q   <= '0;
									state_q <= ST_PRD;
								end else if (total_q[rar_pkg::SHOT_W]) begin
									shot_q       <= rar_pkg::SHOT_MAX;
									res_status_q <= rar_pkg::ST_SAT;
								end else begin
									shot_q <= total_q[rar_pkg::SHOT_W-1:0];
								end
							end
							default: ;
						endcase
					end
				end
				ST_PRD: state_q <= ST_PDAT;
				ST_PDAT: begin
					if (sreq.start) begin
						state_q <= ST_PDIV;
					end else if (cnt_q == rar_pkg::LAST_ADDR) begin
						state_q <= retag_q ? ST_ERD : ST_FIN;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_PRD;
					end
				end
				ST_PDIV: begin
					if (srsp.done) begin
						if (cnt_q == rar_pkg::LAST_ADDR) begin
							state_q <= ST_FIN;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_PRD;
						end
					end
				end
				ST_FIN: begin
					if (!ovalid_q || results.ready) begin
						ovalid_q  <= 1'b1;
						oindex_q  <= res_wrote_q ? rar_pkg::idx_t'(addr_q) : '0;
						osum_q    <= res_wrote_q ? res_sum_q : '0;
						oshots_q  <= shot_q;
						odone_q   <= last_q;
						ostatus_q <= res_status_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid       = ovalid_q;
	assign results.out_index   = oindex_q;
	assign results.out_sum     = osum_q;
	assign results.out_shots   = oshots_q;
	assign results.record_done = odone_q;
	assign results.status      = ostatus_q;

endmodule

// File: sim/rar_checker.sv
// Result checker: predicts each result from accepted samples and compares.
module rar_checker
	import rar_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	rar_in_if                    samples,
	rar_out_if                   results,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [IDX_W-1:0]  index;
		logic [SUM_W-1:0]  sum;
		logic [SHOT_W-1:0] shots;
		logic              done;
		logic [ST_W-1:0]   status;
	} result_t;

	result_t           expected_results[$];
	logic [SUM_W-1:0]  sums[RECORD_LEN];
	bit                touched[RECORD_LEN];
	logic [SHOT_W-1:0] shot_count;
	logic [TOT_W-1:0]  total_latched;
	logic              averaging;
	logic [SHIFT_W-1:0] shift_reg;
	logic [TGT_W-1:0]  target_reg;

	assign pending = expected_results.size();

	function automatic logic [SUM_W-1:0] scale_round(logic neg, logic [SUM_W-1:0] mag,
			logic [TGT_W-1:0] num, logic [TOT_W-1:0] den);
		logic [127:0] acc, q;
		if (den == '0)
			return '0;
		acc = 128'(mag) * 128'(num) + 128'(den >> 1);
		q = acc / 128'(den);
		if (!neg)
			return (q > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
		return (q > 128'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : -q[63:0];
	endfunction

	function automatic logic [SHOT_W-1:0] sat_shots(logic [TOT_W-1:0] v,
			ref logic [ST_W-1:0] st);
		if (v > TOT_W'(SHOT_MAX)) begin
			st = ST_SAT;
			return SHOT_MAX;
		end
		return v[SHOT_W-1:0];
	endfunction

	task automatic predict_sample(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
			logic [VAL_W-1:0] raw, logic [INC_W-1:0] inc, logic last);
		logic [SUM_W-1:0] val, s, t, mag;
		logic [ST_W-1:0]  st;
		int               pos, p;
		bit               inr, wrote, scaling, an, bn, neg;
		result_t          r;
		val = {{(SUM_W-VAL_W){raw[VAL_W-1]}}, raw};
		st = ST_OK;
		wrote = 0;
		pos = int'(idx);
		if (cmd == CMD_SHIFT || cmd == CMD_AVG)
			pos += int'($signed(shift_reg));
		if (cmd != CMD_AVG && averaging) begin
			averaging = 0;
			touched = '{default: 0};
		end
		if (cmd == CMD_AVG && !averaging) begin
			averaging = 1;
			total_latched = TOT_W'(shot_count) + TOT_W'(inc);
			touched = '{default: 0};
		end
		inr = pos >= 0 && pos < int'(RECORD_LEN);
		p = inr ? pos : 0;
		scaling = cmd == CMD_AVG && total_latched > TOT_W'(target_reg);
		if (inr && cmd <= CMD_READ) begin
			wrote = 1;
			s = sums[p];
			if (cmd == CMD_RAW || cmd == CMD_SHIFT || (cmd == CMD_AVG && !scaling))
				s = s + val;
			else if (cmd == CMD_SUB)
				s = s - val;
			else if (cmd == CMD_COPY)
				s = val;
			else if (cmd == CMD_AVG) begin
				an = s[63];
				bn = val[63];
				if (!an && !bn) begin
					neg = 0;
					mag = s + val;
				end else if (an && bn) begin
					neg = 1;
					mag = -s - val;
				end else begin
					t = s + val;
					neg = t[63];
					mag = neg ? -t : t;
				end
				s = scale_round(neg, mag, target_reg, total_latched);
				touched[p] = 1;
			end
			sums[p] = s;
		end
		if (last) begin
			case (cmd)
				CMD_RAW, CMD_COPY: shot_count = sat_shots(TOT_W'(shot_count) + 1, st);
				CMD_SHIFT: shot_count = sat_shots(TOT_W'(shot_count) + TOT_W'(inc), st);
				CMD_SUB: begin
					if (SHOT_W'(inc) > shot_count) begin
						shot_count = '0;
						st = ST_UNDER;
					end else
						shot_count = shot_count - SHOT_W'(inc);
				end
				CMD_AVG: begin
					if (scaling) begin
						for (int q = 0; q < int'(RECORD_LEN); q++)
							if (!touched[q])
								sums[q] = scale_round(sums[q][63],
									sums[q][63] ? -sums[q] : sums[q], target_reg,
									total_latched);
						shot_count = SHOT_W'(target_reg);
					end else
						shot_count = sat_shots(total_latched, st);
					averaging = 0;
					touched = '{default: 0};
				end
				default: ;
			endcase
		end
		r.index = wrote ? IDX_W'(p) : '0;
		r.sum = wrote ? sums[p] : '0;
		r.shots = shot_count;
		r.done = last;
		r.status = st;
		expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums = '{default: '0};
			touched = '{default: 0};
			shot_count = '0;
			total_latched = '0;
			averaging = 0;
			shift_reg = '0;
			target_reg = 1;
			errors = 0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SHIFT:  shift_reg = cfg_wdata[SHIFT_W-1:0];
					REG_TARGET: target_reg = cfg_wdata[TGT_W-1:0];
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				result_t e;
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction");
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (results.out_index !== e.index) begin
						$error("out_index: expected %0d actual %0d", e.index, results.out_index);
						errors++;
					end
					if (results.out_sum !== e.sum) begin
						$error("out_sum: expected %0h actual %0h", e.sum, results.out_sum);
						errors++;
					end
					if (results.out_shots !== e.shots) begin
						$error("out_shots: expected %0h actual %0h", e.shots, results.out_shots);
						errors++;
					end
					if (results.record_done !== e.done) begin
						$error("record_done: expected %0b actual %0b", e.done,
							results.record_done);
						errors++;
					end
					if (results.status !== e.status) begin
						$error("status: expected %0d actual %0d", e.status, results.status);
						errors++;
					end
				end
			end
			if (samples.valid && samples.ready)
				predict_sample(samples.cmd, samples.sample_index, samples.sample_value,
					samples.incoming_shots, samples.last_sample);
		end
	end
endmodule

// File: sim/tb.sv
// Testbench top: clock, reset, stimulus, configuration and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rar_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
	localparam longint CYCLE_LIMIT = 20_000_000;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SHIFT;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	bit                   calm = 0;
	int                   errors, pending;
	longint               cycles = 0;

	rar_in_if  samples();
	rar_out_if results();

	record_averaging_accumulator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .samples(samples), .results(results)
	);

	rar_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .samples(samples), .results(results),
		.errors(errors), .pending(pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		results.ready = 0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				results.ready <= 0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			results.ready <= 1;
		end
	end

	task automatic send_sample(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
			logic [VAL_W-1:0] val, logic [INC_W-1:0] inc, logic last);
		if (!calm && $urandom_range(0, 9) == 0) begin
			samples.valid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		samples.valid <= 1;
		samples.cmd <= cmd;
		samples.sample_index <= idx;
		samples.sample_value <= val;
		samples.incoming_shots <= inc;
		samples.last_sample <= last;
		do @(posedge clk); while (!samples.ready);
	endtask

	// drain all results before touching configuration
	task automatic wait_quiet();
		samples.valid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
		cfg_we <= 1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 3))
			0: return VAL_W'($urandom_range(0, 20)) - 10;
			1: return {1'b0, {(VAL_W-1){1'b1}}};
			default: return VAL_W'({$urandom, $urandom});
		endcase
	endfunction

	function automatic logic [INC_W-1:0] rand_shots();
		return $urandom_range(0, 1) ? INC_W'($urandom_range(0, 16)) : $urandom;
	endfunction

	task automatic send_record(ref int count);
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] idx;
		logic [INC_W-1:0] inc;
		int               len;
		len = $urandom_range(1, 8);
		idx = $urandom_range(0, 3) == 0 ? IDX_W'(RECORD_LEN - 4) : IDX_W'($urandom);
		inc = rand_shots();
		case ($urandom_range(0, 15))
			0, 1, 2: cmd = CMD_RAW;
			3, 4, 5: cmd = CMD_SHIFT;
			6, 7, 8: cmd = CMD_AVG;
			9, 10:   cmd = CMD_SUB;
			11:      cmd = CMD_COPY;
			12, 13:  cmd = CMD_READ;
			14:      cmd = CMD_RSVD6;
			default: cmd = CMD_RSVD7;
		endcase
		for (int i = 0; i < len; i++) begin
			// an average never completes here: that could sweep the whole store
			if (cmd == CMD_AVG)
				send_sample(cmd, idx + IDX_W'(i), rand_value(), inc, 1'b0);
			else
				send_sample(cmd, idx + IDX_W'(i), rand_value(), inc,
					i == len - 1 || $urandom_range(0, 15) == 0);
			count++;
		end
		if (cmd == CMD_AVG) begin
			send_sample(CMD_READ, idx, rand_value(), rand_shots(), $urandom_range(0, 1));
			count++;
		end
	endtask

	initial begin
		int count;
		samples.valid = 0;
		samples.cmd = CMD_RAW;
		samples.sample_index = '0;
		samples.sample_value = '0;
		samples.incoming_shots = '0;
		samples.last_sample = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_reg(REG_SHIFT, '0);
		write_reg(REG_TARGET, 1);
		send_sample(CMD_RAW, '0, {1'b0, {(VAL_W-1){1'b1}}}, '0, 0);
		send_sample(CMD_RAW, '1, {1'b1, {(VAL_W-1){1'b0}}}, '1, 1);
		send_sample(CMD_COPY, 5, '1, '0, 1);
		send_sample(CMD_SUB, 0, 1, '1, 1);
		send_sample(CMD_READ, '1, '0, '0, 0);
		send_sample(CMD_RSVD6, 1, 3, 3, 1);
		send_sample(CMD_RSVD7, 2, 3, 3, 1);
		send_sample(CMD_SUB, 3, '1, '0, 1);
		wait_quiet();
		write_reg(REG_SHIFT, 32'h3FFF);
		send_sample(CMD_SHIFT, 1, 9, 9, 0);
		send_sample(CMD_SHIFT, 0, {1'b0, {(VAL_W-1){1'b1}}}, '1, 1);
		wait_quiet();
		write_reg(REG_SHIFT, 32'h4001);
		send_sample(CMD_SHIFT, 0, 9, 9, 0);
		send_sample(CMD_SHIFT, '1, -5, 5, 1);
		wait_quiet();
		write_reg(REG_SHIFT, '0);
		write_reg(REG_TARGET, '1);
		send_sample(CMD_AVG, 20, 7, 3, 0);
		send_sample(CMD_AVG, 21, -7, 3, 1);
		send_sample(CMD_AVG, 22, 1, 2, 0);
		send_sample(CMD_READ, 22, 0, 0, 0);
		wait_quiet();
		write_reg(REG_TARGET, 1);
		send_sample(CMD_AVG, 10, 1, 1, 0);
		send_sample(CMD_AVG, 11, -1, 0, 0);
		send_sample(CMD_AVG, 12, {1'b0, {(VAL_W-1){1'b1}}}, 0, 1);
		wait_quiet();
		write_reg(REG_TARGET, 0);
		send_sample(CMD_AVG, 30, -5, 1, 1);
		wait_quiet();

		// drive the shot count into saturation
		write_reg(REG_TARGET, 1);
		for (int i = 0; i < 258; i++)
			send_sample(CMD_SHIFT, IDX_W'($urandom), rand_value(), '1, 1);

		for (int ph = 0; ph < 8; ph++) begin
			wait_quiet();
			case (ph % 4)
				0: write_reg(REG_SHIFT, 32'h3FFF);
				1: write_reg(REG_SHIFT, 32'h4001);
				2: write_reg(REG_SHIFT, '0);
				default: write_reg(REG_SHIFT, $urandom_range(0, 32767) == 16384 ?
					32'h0 : $urandom_range(0, 32767));
			endcase
			case (ph % 3)
				0: write_reg(REG_TARGET, '1);
				1: write_reg(REG_TARGET, ph == 1 ? 0 : 1);
				default: write_reg(REG_TARGET, $urandom);
			endcase
			if (ph == 7)
				calm = 1;
			count = 0;
			while (count < 90)
				send_record(count);
		end
		samples.valid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// File: filelist.f
hdl/rar_pkg.sv
hdl/rar_if.sv
hdl/rar_ram.sv
hdl/rar_scale.sv
hdl/record_averaging_accumulator.sv
sim/rar_checker.sv
sim/tb.sv
